/* hdl/pfe_pkg.sv */
`timescale 1ns / 1ps

package pfe_pkg;

  // Field widths
  localparam int CMD_W = 2;
  localparam int LET_W = 5;
  localparam int POS_W = 3;
  localparam int RC_W  = 2 * POS_W;

  // Square geometry and alphabet
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int NUM_LET = 26;
  localparam int SQ_AW   = $clog2(CELLS);
  localparam int MAP_AW  = $clog2(NUM_LET);

  // Letter codes
  localparam logic [LET_W-1:0] LET_I   = LET_W'(8);
  localparam logic [LET_W-1:0] LET_J   = LET_W'(9);
  localparam logic [LET_W-1:0] LET_X   = LET_W'(23);
  localparam logic [LET_W-1:0] LET_Z   = LET_W'(25);
  localparam logic [LET_W-1:0] LET_MAX = LET_W'(NUM_LET - 1);

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_LOOK_A,
    S_LOOK_B,
    S_CALC,
    S_SQ_A,
    S_SQ_B,
    S_SQ_C,
    S_OUT_A,
    S_OUT_B
  } state_t;

  // Filler inserted after a letter: z after x, x otherwise
  function automatic logic [LET_W-1:0] filler_for(input logic [LET_W-1:0] ch);
    return (ch == LET_X) ? LET_Z : LET_X;
  endfunction

  // Next row or column, wrapping at the square edge
  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] v);
    return (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
  endfunction

  // Row-major cell address: row * 5 + col
  function automatic logic [SQ_AW-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col);
    return SQ_AW'({row, 2'b00}) + SQ_AW'(row) + SQ_AW'(col);
  endfunction

endpackage

/* hdl/pfe_in_if.sv */
`timescale 1ns / 1ps

interface pfe_in_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [LET_W-1:0] letter;

  modport source (output valid, output cmd, output letter, input ready);
  modport sink   (input valid, input cmd, input letter, output ready);
endinterface

/* hdl/pfe_out_if.sv */
`timescale 1ns / 1ps

interface pfe_out_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [LET_W-1:0] out_letter;
  logic             run_last;

  modport source (output valid, output out_letter, output run_last, input ready);
  modport sink   (input valid, input out_letter, input run_last, output ready);
endinterface

/* hdl/pfe_ram.sv */
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/playfair_digraph_encrypt.sv */
`timescale 1ns / 1ps

// Playfair encryptor. One input channel (din) carries commands: key letter,
// finish key square, plaintext letter, end of text. One output channel (dout)
// carries ciphertext letters, two per encrypted pair, run_last set on the
// second. Each transfer on din is handled completely before din is ready again.
// Steps per input item:
//   key letter ......... transfer, decode/place
//   finish ............. walk of the 26 letters, one per cycle
//   text letter, no pair transfer, decode
//   text letter or end of text closing a pair: transfer, decode, two map
//     reads, address calculation, two square reads, then the two results;
//     the two letter-map reads and two square reads share one read port each.
// A stalled dout holds the current result and the block waits; nothing is
// dropped. Reset (rst, synchronous) empties the square and the open pair and
// returns to idle; square and map memories keep their contents, and map
// entries are not consulted until rewritten.
module playfair_digraph_encrypt (
  input  logic      clk,
  input  logic      rst,
  pfe_in_if.sink    din,
  pfe_out_if.source dout
);
  import pfe_pkg::*;

  state_t state, state_next;

  // Item and square state
  cmd_t                cmd_r;
  logic [LET_W-1:0]    ch_r;
  logic [NUM_LET-1:0]  placed, placed_next;
  logic [SQ_AW-1:0]    fill_count, fill_count_next;
  logic [POS_W-1:0]    fill_row, fill_row_next;
  logic [POS_W-1:0]    fill_col, fill_col_next;
  logic                square_done;
  logic [LET_W-1:0]    walk;
  logic [LET_W-1:0]    held_letter;
  logic                held_valid;
  logic [LET_W-1:0]    prev_letter;
  logic                prev_valid;

  // Pair datapath
  logic [LET_W-1:0]    pa, pb;
  logic [RC_W-1:0]     rc_a, rc_b;
  logic [SQ_AW-1:0]    addr1, addr2;
  logic [LET_W-1:0]    e1, e2;

  // Memory ports
  logic                sq_we, map_we;
  logic [SQ_AW-1:0]    sq_waddr, sq_raddr;
  logic [LET_W-1:0]    sq_wdata, sq_rdata;
  logic [MAP_AW-1:0]   map_waddr, map_raddr;
  logic [RC_W-1:0]     map_wdata, map_rdata;

  // Placement unit
  logic                key_ok, key_clear, place_req, place_do;
  logic [LET_W-1:0]    place_ch, ch_in;
  logic [NUM_LET-1:0]  base_placed;
  logic [SQ_AW-1:0]    base_count;
  logic [POS_W-1:0]    base_row, base_col;

  // Text decode
  logic                text_ok, need_fill, pair_go;
  logic [LET_W-1:0]    fil;

  // Pair geometry
  logic [POS_W-1:0]    r1, c1, r2, c2;

  pfe_ram #(.WIDTH(LET_W), .DEPTH(CELLS)) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (sq_waddr),
    .wdata (sq_wdata),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  pfe_ram #(.WIDTH(RC_W), .DEPTH(NUM_LET)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // j is taken as i on entry
  assign ch_in = (din.letter == LET_J) ? LET_I : din.letter;

  // Text decode terms
  always_comb begin
    text_ok   = (cmd_r == CMD_TEXT) && (ch_r <= LET_MAX);
    need_fill = prev_valid && (prev_letter == ch_r);
    fil       = filler_for(ch_r);
    pair_go   = (text_ok && (need_fill || held_valid)) ||
                ((cmd_r == CMD_END) && held_valid);
  end

  // Placement: a key letter after a finish starts a fresh square
  always_comb begin
    key_ok      = (state == S_DECODE) && (cmd_r == CMD_KEY) && (ch_r <= LET_MAX);
    key_clear   = key_ok && square_done;
    base_placed = key_clear ? '0 : placed;
    base_count  = key_clear ? '0 : fill_count;
    base_row    = key_clear ? '0 : fill_row;
    base_col    = key_clear ? '0 : fill_col;
    place_req   = 1'b0;
    place_ch    = ch_r;
    if (key_ok) begin
      place_req = !base_placed[ch_r];
    end else if (state == S_FILL) begin
      place_ch  = walk;
      place_req = (walk != LET_J) && !placed[walk];
    end
    place_do = place_req && (base_count != SQ_AW'(CELLS));

    placed_next     = base_placed;
    fill_count_next = base_count;
    fill_row_next   = base_row;
    fill_col_next   = base_col;
    if (place_do) begin
      placed_next     = base_placed | (NUM_LET'(1) << place_ch);
      fill_count_next = base_count + SQ_AW'(1);
      fill_col_next   = wrap_inc(base_col);
      fill_row_next   = (base_col == POS_W'(SIDE - 1)) ? base_row + POS_W'(1) : base_row;
    end
  end

  // Pair geometry: row and column of both letters
  always_comb begin
    rc_b = placed[pb] ? map_rdata : '0;
    r1   = rc_a[RC_W-1:POS_W];
    c1   = rc_a[POS_W-1:0];
    r2   = rc_b[RC_W-1:POS_W];
    c2   = rc_b[POS_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (din.valid) state_next = S_DECODE;
      S_DECODE: begin
        if (cmd_r == CMD_FINISH) state_next = S_FILL;
        else if (pair_go)        state_next = S_LOOK_A;
        else                     state_next = S_IDLE;
      end
      S_FILL:   if (walk == LET_MAX) state_next = S_IDLE;
      S_LOOK_A: state_next = S_LOOK_B;
      S_LOOK_B: state_next = S_CALC;
      S_CALC:   state_next = S_SQ_A;
      S_SQ_A:   state_next = S_SQ_B;
      S_SQ_B:   state_next = S_SQ_C;
      S_SQ_C:   state_next = S_OUT_A;
      S_OUT_A:  if (dout.ready) state_next = S_OUT_B;
      S_OUT_B:  if (dout.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    din.ready       = (state == S_IDLE);
    dout.valid      = (state == S_OUT_A) || (state == S_OUT_B);
    dout.out_letter = (state == S_OUT_B) ? e2 : e1;
    dout.run_last   = (state == S_OUT_B);
    sq_we     = place_do;
    sq_waddr  = base_count;
    sq_wdata  = place_ch;
    map_we    = place_do;
    map_waddr = place_ch;
    map_wdata = {base_row, base_col};
    map_raddr = (state == S_LOOK_B) ? pb : pa;
    sq_raddr  = (state == S_SQ_B) ? addr2 : addr1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      placed      <= '0;
      fill_count  <= '0;
      fill_row    <= '0;
      fill_col    <= '0;
      square_done <= 1'b0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      prev_letter <= '0;
      prev_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      placed     <= placed_next;
      fill_count <= fill_count_next;
      fill_row   <= fill_row_next;
      fill_col   <= fill_col_next;
      if (key_clear) begin
        square_done <= 1'b0;
      end
      if (state == S_FILL && walk == LET_MAX) begin
        square_done <= 1'b1;
      end
      if (state == S_DECODE) begin
        // Text stream: filler between equal neighbors, then the letter
        if (text_ok) begin
          prev_letter <= ch_r;
          prev_valid  <= 1'b1;
          if (need_fill && !held_valid) begin
            held_valid <= 1'b0;
          end else if (!need_fill && held_valid) begin
            held_valid <= 1'b0;
          end else begin
            held_letter <= ch_r;
            held_valid  <= 1'b1;
          end
        end else if (cmd_r == CMD_END) begin
          prev_valid <= 1'b0;
          held_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && din.valid) begin
      cmd_r <= cmd_t'(din.cmd);
      ch_r  <= ch_in;
      walk  <= '0;
    end
    if (state == S_FILL) begin
      walk <= walk + LET_W'(1);
    end
    if (state == S_DECODE) begin
      if (text_ok) begin
        if (need_fill && held_valid) begin
          pa <= held_letter;
          pb <= fil;
        end else if (need_fill) begin
          pa <= fil;
          pb <= ch_r;
        end else begin
          pa <= held_letter;
          pb <= ch_r;
        end
      end else begin
        pa <= held_letter;
        pb <= filler_for(held_letter);
      end
    end
    if (state == S_LOOK_B) begin
      rc_a <= placed[pa] ? map_rdata : '0;
    end
    if (state == S_CALC) begin
      if (r1 == r2) begin
        addr1 <= cell_addr(r1, wrap_inc(c1));
        addr2 <= cell_addr(r1, wrap_inc(c2));
      end else if (c1 == c2) begin
        addr1 <= cell_addr(wrap_inc(r1), c1);
        addr2 <= cell_addr(wrap_inc(r2), c1);
      end else begin
        addr1 <= cell_addr(r1, c2);
        addr2 <= cell_addr(r2, c1);
      end
    end
    if (state == S_SQ_B) begin
      e1 <= sq_rdata;
    end
    if (state == S_SQ_C) begin
      e2 <= sq_rdata;
    end
  end

endmodule
